// ===== rtl/dwcb_pkg.sv =====
// Package for the debounced write-coalescing buffer.
// Holds sizes, payload structs, the cell chain struct and the controller states.
// No dependencies.
package dwcb_pkg;

  localparam int SLOTS       = 8;
  localparam int RECORD_BITS = 64;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] device_id;
    logic [63:0] record_data;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_id;
    logic [63:0] out_record;
    logic        hit;
    logic        last;
  } out_t;

  // Carried from cell to cell: first-found flags and the wired-OR read bus.
  typedef struct packed {
    logic                   match_found;
    logic                   free_found;
    logic                   pend_found;
    logic [31:0]            key;
    logic [RECORD_BITS-1:0] payload;
    logic [31:0]            stamp;
  } chain_t;

  // Per-cell controls from the sequencer.
  typedef struct packed {
    logic rd_sel;
    logic wr;
    logic clr;
    logic pend_load;
  } cell_ctl_t;

  // Per-cell status to the sequencer.
  typedef struct packed {
    logic used;
    logic match;
    logic match_pick;
    logic free_pick;
    logic pend;
    logic pend_pick;
  } cell_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_EVICT,
    ST_LOOK,
    ST_TLATCH,
    ST_TICK
  } state_t;

endpackage

// ===== rtl/dwcb_cell.sv =====
// One slot of the buffer: used flag, key, payload, stamp and tick-pending flag.
// Depends on dwcb_pkg; chained to its neighbors through chain_t.
module dwcb_cell
  import dwcb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctl_t              ctl,
  input  logic [31:0]            id,
  input  logic [31:0]            now,
  input  logic [31:0]            delay,
  input  logic [RECORD_BITS-1:0] wr_payload,
  input  chain_t                 chain_in,
  output chain_t                 chain_out,
  output cell_sts_t              sts
);

  logic                   used;
  logic                   pend;
  logic [31:0]            key;
  logic [RECORD_BITS-1:0] payload;
  logic [31:0]            stamp;
  logic [31:0]            age;
  logic                   match;
  logic                   due;

  assign age   = now - stamp;
  assign match = used && (key == id);
  assign due   = used && (age >= delay);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (ctl.wr) begin
        used <= 1'b1;
      end else if (ctl.clr) begin
        used <= 1'b0;
      end
      if (ctl.pend_load) begin
        pend <= due;
      end else if (ctl.clr) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key     <= id;
      payload <= wr_payload;
      stamp   <= now;
    end
  end

  always_comb begin
    chain_out.match_found = chain_in.match_found | match;
    chain_out.free_found  = chain_in.free_found | !used;
    chain_out.pend_found  = chain_in.pend_found | pend;
    chain_out.key         = chain_in.key | (ctl.rd_sel ? key : 32'd0);
    chain_out.payload     = chain_in.payload | (ctl.rd_sel ? payload : '0);
    chain_out.stamp       = chain_in.stamp | (ctl.rd_sel ? stamp : 32'd0);
    sts.used       = used;
    sts.match      = match;
    sts.match_pick = match && !chain_in.match_found;
    sts.free_pick  = !used && !chain_in.free_found;
    sts.pend       = pend;
    sts.pend_pick  = pend && !chain_in.pend_found;
  end

endmodule

// ===== rtl/debounced_write_coalescing_buffer.sv =====
// Top level of the debounced write-coalescing buffer: sequencer and slot chain.
// Depends on dwcb_pkg and dwcb_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------
//  in      | input     | in_valid / in_ready   | in_data (in_t)
//  out     | output    | out_valid / out_ready | out_data (out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (save_delay)
//
// Sequence: a lookup is answered from LOOK; an update that hits or finds a free
// slot is written in UPD. An update into a full buffer walks the stamps one slot
// a cycle in SCAN to find the oldest, then evicts it in EVICT. A tick latches the
// due flags in TLATCH, then flushes one pending slot per output transfer in TICK.
// Reset (synchronous) frees every slot and sets save_delay to 5000.
// A stalled output holds the sequencer in place; a new input is taken only
// once the previous one has issued its last transfer into the output register.
module debounced_write_coalescing_buffer
  import dwcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [31:0]            save_delay;
  logic [31:0]            id;
  logic [RECORD_BITS-1:0] data;
  logic [31:0]            now;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] min_idx;
  logic [31:0]      min_stamp;

  cell_ctl_t ctl [SLOTS];
  cell_sts_t sts [SLOTS];
  chain_t    chain [SLOTS+1];

  logic [SLOTS-1:0] used_vec;
  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] match_pick;
  logic [SLOTS-1:0] free_pick;
  logic [SLOTS-1:0] pend_vec;
  logic [SLOTS-1:0] pend_pick;
  logic [SLOTS-1:0] idx_hot;
  logic [SLOTS-1:0] min_hot;
  logic [SLOTS-1:0] rd_sel;
  logic [SLOTS-1:0] wr_vec;
  logic [SLOTS-1:0] clr_vec;
  logic             pend_load;
  logic             out_free;
  logic             out_load;
  out_t             out_next;
  logic             match_any;
  logic             free_any;
  logic             scan_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign match_any = |match_vec;
  assign free_any  = |free_pick;
  assign scan_end  = (idx == IDX_W'(SLOTS - 1));

  // Head of the chain: nothing found yet, read bus empty.
  assign chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      ctl[i].rd_sel    = rd_sel[i];
      ctl[i].wr        = wr_vec[i];
      ctl[i].clr       = clr_vec[i];
      ctl[i].pend_load = pend_load;
      used_vec[i]   = sts[i].used;
      match_vec[i]  = sts[i].match;
      match_pick[i] = sts[i].match_pick;
      free_pick[i]  = sts[i].free_pick;
      pend_vec[i]   = sts[i].pend;
      pend_pick[i]  = sts[i].pend_pick;
      idx_hot[i]    = (idx == IDX_W'(i));
      min_hot[i]    = (min_idx == IDX_W'(i));
    end

    dwcb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[i]),
      .id         (id),
      .now        (now),
      .delay      (save_delay),
      .wr_payload (data),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .sts        (sts[i])
    );
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      save_delay <= 32'd5000;
    end else if (cfg_valid && cfg_ready) begin
      save_delay <= cfg_data;
    end
  end

  // Capture the accepted item; unused opcodes are dropped in IDLE.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id   <= in_data.device_id;
      data <= in_data.record_data[RECORD_BITS-1:0];
      now  <= in_data.now_ms;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_UPDATE: state_next = ST_UPD;
            OP_LOOKUP: state_next = ST_LOOK;
            OP_TICK:   state_next = ST_TLATCH;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPD: begin
        if (match_any || free_any) begin
          state_next = ST_IDLE;
        end else if (SLOTS > 1) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EVICT;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TLATCH: state_next = ST_TICK;
      ST_TICK: begin
        if (pend_vec == '0) begin
          state_next = ST_IDLE;
        end else if (out_free && ((pend_vec & ~pend_pick) == '0)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: read select, slot writes and clears, result load.
  always_comb begin
    rd_sel    = '0;
    wr_vec    = '0;
    clr_vec   = '0;
    pend_load = 1'b0;
    out_load  = 1'b0;
    out_next  = '0;
    case (state)
      ST_UPD: begin
        // Read slot 0 to seed the oldest-stamp walk.
        rd_sel = {{(SLOTS-1){1'b0}}, 1'b1};
        if (match_any) begin
          wr_vec = match_pick;
        end else if (free_any) begin
          wr_vec = free_pick;
        end
      end
      ST_SCAN: rd_sel = idx_hot;
      ST_EVICT: begin
        rd_sel = min_hot;
        if (out_free) begin
          wr_vec   = min_hot;
          out_load = 1'b1;
          out_next.kind       = KIND_FLUSH;
          out_next.out_id     = chain[SLOTS].key;
          out_next.out_record = 64'(chain[SLOTS].payload);
          out_next.hit        = 1'b0;
          out_next.last       = 1'b1;
        end
      end
      ST_LOOK: begin
        rd_sel = match_pick;
        if (out_free) begin
          out_load = 1'b1;
          out_next.kind       = KIND_ANSWER;
          out_next.out_id     = id;
          out_next.out_record = 64'(chain[SLOTS].payload);
          out_next.hit        = match_any;
          out_next.last       = 1'b1;
        end
      end
      ST_TLATCH: pend_load = 1'b1;
      ST_TICK: begin
        rd_sel = pend_pick;
        if (out_free && (pend_vec != '0)) begin
          clr_vec  = pend_pick;
          out_load = 1'b1;
          out_next.kind       = KIND_FLUSH;
          out_next.out_id     = chain[SLOTS].key;
          out_next.out_record = 64'(chain[SLOTS].payload);
          out_next.hit        = 1'b0;
          out_next.last       = ((pend_vec & ~pend_pick) == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Oldest-stamp walk: strict compare keeps the first minimum.
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      idx       <= IDX_W'(1);
      min_idx   <= '0;
      min_stamp <= chain[SLOTS].stamp;
    end else if (state == ST_SCAN) begin
      idx <= idx + IDX_W'(1);
      if (chain[SLOTS].stamp < min_stamp) begin
        min_idx   <= idx;
        min_stamp <= chain[SLOTS].stamp;
      end
    end
  end

  // Output register: hold until the downstream side takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Keys of used slots stay unique.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec)) else $error("two slots hold the same id");

  // Eviction only happens with every slot in use.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVICT) |-> (&used_vec)) else $error("evict with a free slot");

  // Pending tick flushes refer only to used slots.
  a_pend_used: assert property (@(posedge clk) disable iff (rst)
    ((pend_vec & ~used_vec) == '0)) else $error("pending flag on a free slot");

  // A lookup answer is always the single, final result of its item.
  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.kind == KIND_ANSWER)) |-> out_data.last)
    else $error("lookup answer without last");

endmodule
